### hdl/linear_key_value_table_macros.svh
// ----------------------------------------------------------------------------
// linear_key_value_table_macros
// Assertion helpers for the key/value table RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// Property that must hold on every clock outside reset
`define LKVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next
`define LKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lkvt_pkg.sv
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared sizes, codes and types for the linear key/value table.
// ----------------------------------------------------------------------------
package lkvt_pkg;

	// table geometry
	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 32;

	// field widths fixed by the interface
	localparam int KEY_PORT_W = 32;
	localparam int VAL_W      = 32;
	localparam int FUNC_W     = 2;
	localparam int STAT_W     = 2;
	localparam int FILL_W     = 5;
	localparam int CAP_W      = 5;
	localparam int APB_W      = 32;
	localparam int ADDR_W     = 3;

	// derived widths
	localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// request codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// register map (word index)
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// per-cell control
	typedef struct packed {
		logic load;   // write the new pair into this cell
		logic shift;  // take the right neighbor's pair
	} cell_ctl_t;

endpackage

### hdl/lkvt_cell.sv
// ----------------------------------------------------------------------------
// lkvt_cell
// One table slot: holds a key/value pair, compares its key with the request
// and shifts in its right neighbor's pair when the table compacts.
// ----------------------------------------------------------------------------
module lkvt_cell (
	input  logic                           clk,
	input  lkvt_pkg::cell_ctl_t            ctl,
	input  logic [lkvt_pkg::KEY_W-1:0]     new_key,
	input  logic [lkvt_pkg::VAL_W-1:0]     new_value,
	input  logic [lkvt_pkg::KEY_W-1:0]     nb_key,
	input  logic [lkvt_pkg::VAL_W-1:0]     nb_value,
	input  logic [lkvt_pkg::KEY_W-1:0]     cmp_key,
	input  logic                           occupied,
	input  logic                           hit_in,
	output logic                           hit_out,
	output logic                           first_hit,
	output logic [lkvt_pkg::KEY_W-1:0]     key_q,
	output logic [lkvt_pkg::VAL_W-1:0]     value_q
);
	import lkvt_pkg::*;

	logic match;

	// compare only slots inside the fill
	assign match     = occupied && (key_q == cmp_key);
	assign hit_out   = hit_in | match;
	assign first_hit = match & ~hit_in;

	// slot storage: insert wins, else compact from the right
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (ctl.shift) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end
	end

endmodule

### hdl/linear_key_value_table.sv
// Sequence: an accepted word enters S_EXEC, which registers the result word and done;
//   a remove with m matching entries goes on in S_SQUEEZE, which registers them once
//   none is left, one compaction shift per match. Busy is high outside S_IDLE.
// The row of cells compares all keys at once; the remove loop sets the rate.
// Reset (arst_n low) empties the table and sets capacity to 16.
// Results cannot be stalled: each word is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// linear_key_value_table
// Packed key/value list in a row of cells with a fill count; insert appends,
// remove deletes all matches and compacts, lookup returns the oldest match.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_macros.svh"

module linear_key_value_table (
	input  logic                              clk,
	input  logic                              arst_n,
	// request
	input  logic                              start,
	output logic                              busy,
	input  logic [lkvt_pkg::FUNC_W-1:0]       func,
	input  logic [lkvt_pkg::KEY_PORT_W-1:0]   key,
	input  logic [lkvt_pkg::VAL_W-1:0]        value,
	// result
	output logic                              done,
	output logic [lkvt_pkg::STAT_W-1:0]       status,
	output logic [lkvt_pkg::VAL_W-1:0]        found_value,
	output logic [lkvt_pkg::FILL_W-1:0]       fill_count,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lkvt_pkg::ADDR_W-1:0]       paddr,
	input  logic [lkvt_pkg::APB_W-1:0]        pwdata,
	output logic [lkvt_pkg::APB_W-1:0]        prdata,
	output logic                              pready
);
	import lkvt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SQUEEZE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      capacity_q;
	logic                  done_q;
	logic [STAT_W-1:0]     status_q;
	logic [VAL_W-1:0]      found_q;
	logic [FILL_W-1:0]     fill_q;

	logic [FUNC_W-1:0]     func_q;
	logic [KEY_W-1:0]      key_q;
	logic [VAL_W-1:0]      value_q;

	cell_ctl_t             ctl      [MAX_ENTRIES];
	logic [KEY_W-1:0]      cell_key [MAX_ENTRIES];
	logic [VAL_W-1:0]      cell_val [MAX_ENTRIES];
	logic [MAX_ENTRIES:0]  hit;
	logic [MAX_ENTRIES-1:0] first_hit;
	logic [MAX_ENTRIES-1:0] occupied;
	logic [MAX_ENTRIES-1:0] load_vec;

	logic                  any_hit;
	logic                  full;
	logic                  do_insert;
	logic                  do_shift;
	logic [CMP_W-1:0]      eff_cap;
	logic [VAL_W-1:0]      found_sel;
	logic                  cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_W-CAP_W){1'b0}}, capacity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// ---------------- request capture ----------------
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q  <= func;
			key_q   <= key[KEY_W-1:0];
			value_q <= value;
		end
	end

	// ---------------- cell row ----------------
	assign hit[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [KEY_W-1:0] nb_key;
		logic [VAL_W-1:0] nb_val;

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign nb_key = cell_key[i];
			assign nb_val = cell_val[i];
		end else begin : g_mid
			assign nb_key = cell_key[i+1];
			assign nb_val = cell_val[i+1];
		end

		assign occupied[i]  = (count_q > CNT_W'(i));
		assign load_vec[i]  = do_insert && (count_q == CNT_W'(i));
		assign ctl[i].load  = load_vec[i];
		// every slot from the first match on moves left one place
		assign ctl[i].shift = do_shift && hit[i+1];

		lkvt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.new_key   (key_q),
			.new_value (value_q),
			.nb_key    (nb_key),
			.nb_value  (nb_val),
			.cmp_key   (key_q),
			.occupied  (occupied[i]),
			.hit_in    (hit[i]),
			.hit_out   (hit[i+1]),
			.first_hit (first_hit[i]),
			.key_q     (cell_key[i]),
			.value_q   (cell_val[i])
		);
	end

	// ---------------- control decode ----------------
	assign any_hit = hit[MAX_ENTRIES];
	assign eff_cap = (CMP_W'(capacity_q) > CMP_W'(MAX_ENTRIES)) ?
		CMP_W'(MAX_ENTRIES) : CMP_W'(capacity_q);
	assign full      = (CMP_W'(count_q) >= eff_cap);
	assign do_insert = (state_q == S_EXEC) && (func_q == FN_INSERT) && !full;
	assign do_shift  = any_hit &&
		(((state_q == S_EXEC) && (func_q == FN_REMOVE)) || (state_q == S_SQUEEZE));

	// oldest matching value, AND-OR select over the one-hot first hit
	always_comb begin
		found_sel = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			found_sel = found_sel | (cell_val[i] & {VAL_W{first_hit[i]}});
		end
	end

	// ---------------- sequencer and result word ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= '0;
			fill_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					found_q <= '0;
					fill_q  <= FILL_W'(count_q);
					status_q <= ST_OK;
					case (func_q)
						FN_INSERT: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
								fill_q  <= FILL_W'(count_q + 1'b1);
							end
						end
						FN_REMOVE: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else if (!any_hit) begin
								status_q <= ST_NOT_FOUND;
							end else begin
								// first entry goes now, the rest in the squeeze loop
								count_q <= count_q - 1'b1;
								state_q <= S_SQUEEZE;
								done_q  <= 1'b0;
							end
						end
						FN_LOOKUP: begin
							if (any_hit) begin
								found_q <= found_sel;
							end else begin
								status_q <= ST_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
				S_SQUEEZE: begin
					if (any_hit) begin
						count_q <= count_q - 1'b1;
					end else begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						found_q  <= '0;
						fill_q   <= FILL_W'(count_q);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign fill_count  = fill_q;

	// ---------------- assertions ----------------
	`LKVT_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES), "fill count above table size")
	`LKVT_ASSERT(a_done_idle, !done_q || (state_q == S_IDLE), "result word while still busy")
	`LKVT_ASSERT(a_one_load, $onehot0(load_vec), "insert writes more than one cell")
	`LKVT_ASSERT_NEXT(a_accept, start && !busy, state_q == S_EXEC, "accepted word not executed")
	`LKVT_ASSERT_NEXT(a_squeeze_down, state_q == S_SQUEEZE, count_q <= $past(count_q), "fill grew during remove")

endmodule

### verif/tb_linear_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_key_value_table
// Self-checking bench for the key/value table. Requests (insert, remove,
// lookup, unused selector) go in over start/busy; a scoreboard table mirrors
// the packed entry list and predicts status, found value and fill for each
// word; every done strobe is checked against the oldest prediction. The
// capacity register is written over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_linear_key_value_table;
	import lkvt_pkg::*;

	// selector with no operation behind it
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	// register addresses: capacity at word 0, word 1 holds no register
	localparam logic [ADDR_W-1:0] CAP_ADDR   = 3'd0;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
	localparam int SETTLE_CYCLES = 24;
	localparam int POOL_N = 6;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  found_value;
		logic [FILL_W-1:0] fill_count;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [FUNC_W-1:0] req_func = '0;
	logic [KEY_PORT_W-1:0] req_key = '0;
	logic [VAL_W-1:0] req_value = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0] pwdata = '0;
	logic busy, done, pready;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0] found_value;
	logic [FILL_W-1:0] fill_count;
	logic [APB_W-1:0] prdata;

	linear_key_value_table DUT (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.func(req_func), .key(req_key), .value(req_value),
		.done(done), .status(status), .found_value(found_value), .fill_count(fill_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// scoreboard copy of the table
	logic [KEY_W-1:0] sb_keys [MAX_ENTRIES];
	logic [VAL_W-1:0] sb_vals [MAX_ENTRIES];
	int sb_fill = 0;
	logic [CAP_W-1:0] sb_cap = CAP_RESET;

	table_reply_t reply_q[$];
	logic [KEY_PORT_W-1:0] key_pool [POOL_N];
	int mismatches = 0;
	int n_req [4] = '{0, 0, 0, 0};
	int n_stat [4] = '{0, 0, 0, 0};
	int n_caps = 0;
	bit no_gaps = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// apply one request to the scoreboard table and return the expected word
	function automatic table_reply_t apply_request(logic [FUNC_W-1:0] fn,
			logic [KEY_PORT_W-1:0] k, logic [VAL_W-1:0] v);
		table_reply_t r;
		int n;
		int kept;
		int lim;
		bit hit;
		r.status = ST_OK;
		r.found_value = '0;
		n = sb_fill;
		lim = (sb_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(sb_cap);
		case (fn)
			FN_INSERT: begin
				if (n >= lim) begin
					r.status = ST_FULL;
				end else begin
					sb_keys[n] = k[KEY_W-1:0];
					sb_vals[n] = v;
					n++;
				end
			end
			FN_REMOVE: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					kept = 0;
					for (int i = 0; i < n; i++) begin
						if (sb_keys[i] != k[KEY_W-1:0]) begin
							sb_keys[kept] = sb_keys[i];
							sb_vals[kept] = sb_vals[i];
							kept++;
						end
					end
					if (kept == n)
						r.status = ST_NOT_FOUND;
					n = kept;
				end
			end
			FN_LOOKUP: begin
				hit = 1'b0;
				for (int i = 0; i < n && !hit; i++) begin
					if (sb_keys[i] == k[KEY_W-1:0]) begin
						r.found_value = sb_vals[i];
						hit = 1'b1;
					end
				end
				if (!hit)
					r.status = ST_NOT_FOUND;
			end
			default: ;
		endcase
		sb_fill = n;
		r.fill_count = n[FILL_W-1:0];
		return r;
	endfunction

	// result checker: every done word against the oldest prediction
	always @(posedge clk) begin
		table_reply_t got, want;
		if (arst_n && done) begin
			got = '{status, found_value, fill_count};
			if (reply_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word %h", $realtime, got);
			end else begin
				want = reply_q.pop_front();
				if (got.status !== want.status || got.found_value !== want.found_value ||
						got.fill_count !== want.fill_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch status %0d/%0d found %h/%h fill %0d/%0d (exp/act)",
							$realtime, want.status, got.status, want.found_value,
							got.found_value, want.fill_count, got.fill_count);
				end
			end
		end
	end

	// idle length: mostly back to back or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// send one request word; returns at the accepting edge with start still high
	task automatic send_request(logic [FUNC_W-1:0] fn, logic [KEY_PORT_W-1:0] k,
			logic [VAL_W-1:0] v);
		int gap;
		table_reply_t exp_word;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_func <= fn;
		req_key <= k;
		req_value <= v;
		do @(posedge clk); while (busy);
		exp_word = apply_request(fn, k, v);
		reply_q.push_back(exp_word);
		n_req[fn]++;
		n_stat[exp_word.status]++;
	endtask

	// drop start and wait until the table has answered everything and gone quiet
	task automatic settle_table();
		start <= 1'b0;
		while (reply_q.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one APB transfer, setup then access; ends on the edge after the access edge
	task automatic apb_transfer(logic wr, logic [ADDR_W-1:0] addr, logic [APB_W-1:0] wdata,
			output logic [APB_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// write a register over APB, track it, then read capacity back
	task automatic write_register(logic [ADDR_W-1:0] addr, logic [APB_W-1:0] data);
		logic [APB_W-1:0] rd;
		apb_transfer(1'b1, addr, data, rd);
		if (addr == CAP_ADDR) begin
			sb_cap = data[CAP_W-1:0];
			n_caps++;
		end
		apb_transfer(1'b0, CAP_ADDR, '0, rd);
		if (rd[CAP_W-1:0] !== sb_cap) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: capacity readback exp %0d got %0d", $realtime, sb_cap,
					rd[CAP_W-1:0]);
		end
	endtask

	// reset value of capacity, and a write to an unmapped word
	task automatic test_register_access();
		logic [APB_W-1:0] rd;
		apb_transfer(1'b0, CAP_ADDR, '0, rd);
		if (rd[CAP_W-1:0] !== CAP_RESET) begin
			mismatches++;
			$display("%0t: capacity after reset exp %0d got %0d", $realtime, CAP_RESET,
				rd[CAP_W-1:0]);
		end
		write_register(SPARE_ADDR, 32'h0000_0003);
	endtask

	// operations and key/value extremes on a table with room to spare
	task automatic test_basic_requests();
		send_request(FN_LOOKUP, '0, '1);
		send_request(FN_REMOVE, '0, '0);
		send_request(FN_UNUSED, '1, '1);
		send_request(FN_INSERT, '0, '0);
		send_request(FN_INSERT, '1, '1);
		send_request(FN_INSERT, '0, 32'h5A5A_5A5A);
		send_request(FN_LOOKUP, '0, '0);
		send_request(FN_LOOKUP, '1, '0);
		send_request(FN_LOOKUP, 32'h1234_5678, '0);
		send_request(FN_REMOVE, 32'h1234_5678, '0);
		send_request(FN_UNUSED, '0, 32'h0000_FFFF);
		// both copies of key 0 go, the remaining entry slides down
		send_request(FN_REMOVE, '0, '1);
		send_request(FN_LOOKUP, '0, '0);
		send_request(FN_REMOVE, '1, '0);
		send_request(FN_LOOKUP, '1, '0);
		settle_table();
	endtask

	// zero capacity, capacity one, and capacity dropped below the fill
	task automatic test_capacity_limits();
		write_register(CAP_ADDR, 32'd0);
		send_request(FN_INSERT, 32'hA, 32'h1);
		settle_table();
		write_register(CAP_ADDR, 32'd1);
		send_request(FN_INSERT, 32'hA, 32'h1);
		send_request(FN_INSERT, 32'hB, 32'h2);
		settle_table();
		write_register(CAP_ADDR, 32'd16);
		send_request(FN_INSERT, 32'hB, 32'h2);
		send_request(FN_INSERT, 32'hC, 32'h3);
		settle_table();
		write_register(CAP_ADDR, 32'd2);
		send_request(FN_INSERT, 32'hD, 32'h4);
		send_request(FN_REMOVE, 32'hA, 32'h0);
		send_request(FN_INSERT, 32'hD, 32'h4);
		send_request(FN_REMOVE, 32'hB, 32'h0);
		send_request(FN_INSERT, 32'hD, 32'h4);
		settle_table();
	endtask

	// one random phase at a fixed capacity; keys mostly from a small pool
	task automatic run_phase(logic [APB_W-1:0] cap, int n_items, int ins_pct, int rem_pct,
			int look_pct, bit burst);
		int r;
		logic [FUNC_W-1:0] fn;
		logic [KEY_PORT_W-1:0] k;
		write_register(CAP_ADDR, cap);
		key_pool[0] = ($urandom_range(0, 1) == 0) ? '0 : '1;
		for (int i = 1; i < POOL_N; i++)
			key_pool[i] = $urandom();
		no_gaps = burst;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct) fn = FN_INSERT;
			else if (r < ins_pct + rem_pct) fn = FN_REMOVE;
			else if (r < ins_pct + rem_pct + look_pct) fn = FN_LOOKUP;
			else fn = FN_UNUSED;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, POOL_N - 1)];
			else
				k = $urandom();
			send_request(fn, k, $urandom());
		end
		no_gaps = 1'b0;
		settle_table();
	endtask

	// capacity sweep including above-limit, zero and one
	task automatic test_random_phases();
		run_phase(32'd31, 100, 55, 15, 25, 1'b0);
		run_phase(32'd1, 60, 35, 25, 35, 1'b0);
		run_phase(32'd0, 50, 30, 30, 35, 1'b0);
		run_phase(32'd16, 100, 50, 15, 30, 1'b1);
		run_phase(32'd5, 80, 40, 20, 35, 1'b0);
		for (int p = 0; p < 3; p++)
			run_phase($urandom_range(0, 31), 80, 45, 20, 30, 1'b0);
		run_phase(32'd16, 60, 20, 50, 25, 1'b0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_basic_requests();
		test_capacity_limits();
		test_random_phases();
		settle_table();
		$display("Covered %0d inserts, %0d removes, %0d lookups, %0d unused over %0d capacity writes",
			n_req[FN_INSERT], n_req[FN_REMOVE], n_req[FN_LOOKUP], n_req[FN_UNUSED], n_caps);
		$display("Answers: %0d ok, %0d full, %0d empty, %0d not found; %0d mismatches",
			n_stat[ST_OK], n_stat[ST_FULL], n_stat[ST_EMPTY], n_stat[ST_NOT_FOUND], mismatches);
		if (mismatches == 0 && reply_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
